### hw/rtl/hid_boot_keyboard_press_detector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyboard press detector
// Clocked on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HID_BOOT_KEYBOARD_PRESS_DETECTOR_ASSERT_SVH
`define HID_BOOT_KEYBOARD_PRESS_DETECTOR_ASSERT_SVH

// Same-cycle implication
`define HBKD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbkd assertion failed");

// Next-cycle implication
`define HBKD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbkd assertion failed");

`endif

### hw/rtl/hbkd_pkg.sv
// ----------------------------------------------------------------------------
// hbkd_pkg
// Shared constants and types of the keyboard press detector.
// ----------------------------------------------------------------------------
package hbkd_pkg;

    // Report geometry
    localparam int SLOT_FIELDS      = 6;
    localparam int SLOTS_PER_REPORT = 6;
    localparam int ACTIVE_SLOTS     = (SLOTS_PER_REPORT < SLOT_FIELDS) ?
                                      SLOTS_PER_REPORT : SLOT_FIELDS;
    localparam int CODE_W           = 8;
    localparam int SLOT_IDX_W       = $clog2(SLOT_FIELDS);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CODE_W-1:0] code_t;
    typedef code_t [SLOT_FIELDS-1:0] slots_t;

    // One classified report: its codes and which of them are new presses
    typedef struct packed {
        slots_t                 code;
        logic [SLOT_FIELDS-1:0] emit;
    } hbkd_entry_t;

    // Front to queue
    typedef struct packed {
        logic        valid;
        hbkd_entry_t entry;
    } hbkd_push_t;

    // Queue head to back
    typedef struct packed {
        logic        empty;
        hbkd_entry_t entry;
    } hbkd_head_t;

endpackage

### hw/rtl/hbkd_front.sv
// ----------------------------------------------------------------------------
// hbkd_front
// Takes a report, compares it with the previous one and marks new presses.
// ----------------------------------------------------------------------------
module hbkd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  hbkd_pkg::slots_t   slots,
    output hbkd_pkg::hbkd_push_t push_out
);
    import hbkd_pkg::*;

    // The pressed map always equals the set of nonzero codes of the previous
    // report, so it is tracked through the stored slots.
    slots_t                 prior_reg;
    slots_t                 now;
    logic [SLOT_FIELDS-1:0] emit;

    // Mask unused slots, then classify each slot
    always_comb
    begin
        logic seen;
        for (int i = 0; i < SLOT_FIELDS; i++)
        begin
            now[i] = (i < ACTIVE_SLOTS) ? slots[i] : '0;
        end
        for (int i = 0; i < SLOT_FIELDS; i++)
        begin
            seen = 1'b0;
            for (int j = 0; j < SLOT_FIELDS; j++)
            begin
                // held in the previous report
                if (prior_reg[j] == now[i])
                    seen = 1'b1;
                // duplicate of an earlier slot of this report
                if ((j < i) && (now[j] == now[i]))
                    seen = 1'b1;
            end
            emit[i] = (now[i] != '0) && !seen;
        end
    end

    // Previous report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prior_reg <= '0;
        else if (accept)
            prior_reg <= now;
    end

    // Only reports with at least one press enter the queue
    assign push_out.valid      = accept && (|emit);
    assign push_out.entry.code = now;
    assign push_out.entry.emit = emit;

endmodule

### hw/rtl/hbkd_queue.sv
// ----------------------------------------------------------------------------
// hbkd_queue
// Short queue of classified reports between front and back.
// ----------------------------------------------------------------------------
module hbkd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hbkd_pkg::hbkd_push_t push_in,
    input  logic                 deq,
    output logic                 full,
    output hbkd_pkg::hbkd_head_t head
);
    import hbkd_pkg::*;

    hbkd_entry_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QCNT_W-1:0]       count_reg;
    logic                    do_deq;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.empty = (count_reg == '0);
    assign head.entry = entry_reg[rd_ptr_reg];
    assign do_deq     = deq && !head.empty;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push_in.valid)
            entry_reg[wr_ptr_reg] <= push_in.entry;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_in.valid)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_deq)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push_in.valid && !do_deq)
                count_reg <= count_reg + 1'b1;
            else if (do_deq && !push_in.valid)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### hw/rtl/hbkd_back.sv
// ----------------------------------------------------------------------------
// hbkd_back
// Walks the head report's marked slots, one press item per cycle while popped.
// ----------------------------------------------------------------------------
module hbkd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hbkd_pkg::hbkd_head_t head,
    input  logic                 pop,
    output logic                 deq,
    output logic                 empty,
    output hbkd_pkg::code_t      pressed_code,
    output logic                 last_of_run
);
    import hbkd_pkg::*;

    logic [SLOT_FIELDS-1:0] sent_reg;
    logic [SLOT_FIELDS-1:0] remaining;
    logic [SLOT_FIELDS-1:0] sel;
    logic [SLOT_IDX_W-1:0]  idx;
    logic                   take;

    assign remaining = head.entry.emit & ~sent_reg;

    // Lowest remaining slot goes out first
    always_comb
    begin
        logic found;
        found = 1'b0;
        sel   = '0;
        idx   = '0;
        for (int i = 0; i < SLOT_FIELDS; i++)
        begin
            if (remaining[i] && !found)
            begin
                sel[i] = 1'b1;
                idx    = SLOT_IDX_W'(i);
                found  = 1'b1;
            end
        end
    end

    assign empty        = head.empty;
    assign pressed_code = head.entry.code[idx];
    assign last_of_run  = ((remaining & ~sel) == '0);
    assign take         = pop && !head.empty;
    assign deq          = take && last_of_run;

    // Slots already delivered from the head report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sent_reg <= '0;
        else if (take)
            sent_reg <= last_of_run ? '0 : (sent_reg | sel);
    end

endmodule

### hw/rtl/hid_boot_keyboard_press_detector.sv
// Flow: an accepted report with at least one new press is registered into the
//   report queue; its press items reach the result ports at the queue head.
// Throughput: one report per cycle while the two-entry report queue has room;
//   press items leave one per cycle while pop is high, up to six per report.
// Reset: rst_n clears the previous-report slots and empties the queue.
// ----------------------------------------------------------------------------
// hid_boot_keyboard_press_detector
// Emits the newly pressed key codes of boot-protocol keyboard reports.
// ----------------------------------------------------------------------------
module hid_boot_keyboard_press_detector (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  hbkd_pkg::code_t       key_slot_0,
    input  hbkd_pkg::code_t       key_slot_1,
    input  hbkd_pkg::code_t       key_slot_2,
    input  hbkd_pkg::code_t       key_slot_3,
    input  hbkd_pkg::code_t       key_slot_4,
    input  hbkd_pkg::code_t       key_slot_5,
    output logic                  empty,
    input  logic                  pop,
    output hbkd_pkg::code_t       pressed_code,
    output logic                  last_of_run
);
    import hbkd_pkg::*;

    slots_t     slots;
    hbkd_push_t push_bus;
    hbkd_head_t head;
    logic       accept;
    logic       deq;

    assign slots  = {key_slot_5, key_slot_4, key_slot_3,
                     key_slot_2, key_slot_1, key_slot_0};
    assign accept = push && !full;

    // Classify incoming reports
    hbkd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .slots    (slots),
        .push_out (push_bus)
    );

    // Decouple front and back
    hbkd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push_bus),
        .deq     (deq),
        .full    (full),
        .head    (head)
    );

    // Deliver press items
    hbkd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .deq          (deq),
        .empty        (empty),
        .pressed_code (pressed_code),
        .last_of_run  (last_of_run)
    );

endmodule

### hw/rtl/hbkd_checker.sv
// ----------------------------------------------------------------------------
// hbkd_checker
// Port-level checks of the keyboard press detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "hid_boot_keyboard_press_detector_assert.svh"

module hbkd_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            full,
    input logic            empty,
    input logic            pop,
    input hbkd_pkg::code_t pressed_code,
    input logic            last_of_run
);
    // A press item never carries the empty code
    `HBKD_ASSERT_IMPL(a_code_nonzero, !empty, pressed_code != '0)

    // A full queue always has a press item waiting
    `HBKD_ASSERT_IMPL(a_full_not_empty, full, !empty)

    // A waiting item holds until taken
    `HBKD_ASSERT_NEXT(a_item_holds, !empty && !pop,
        !empty && $stable(pressed_code) && $stable(last_of_run))

    // A run does not end without its last marker
    `HBKD_ASSERT_NEXT(a_run_continues, !empty && pop && !last_of_run, !empty)

    // Within one report a code is delivered once
    `HBKD_ASSERT_NEXT(a_no_repeat, !empty && pop && !last_of_run,
        pressed_code != $past(pressed_code))

endmodule

bind hid_boot_keyboard_press_detector hbkd_checker u_hbkd_checker (.*);
